### hdl/ddaa_pkg.sv
// ----------------------------------------------------------------------------
// ddaa_pkg
// Shared constants and types for the decimal digit array adder.
// ----------------------------------------------------------------------------
package ddaa_pkg;

  // Digits kept per operand; one accumulator holds up to 10^MAX_DIGITS - 1.
  localparam int MAX_DIGITS = 16;
  localparam longint unsigned VAL_LIMIT = 64'd10 ** MAX_DIGITS;
  // Accumulator width: smallest w with 2^w > 10^MAX_DIGITS - 1 (54 for 16 digits).
  localparam int VAL_W      = $clog2(VAL_LIMIT);
  localparam int SUM_W      = VAL_W + 1;
  localparam int NDIG       = MAX_DIGITS + 1;
  localparam int BCD_W      = 4 * NDIG;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int BIT_CNT_W  = $clog2(SUM_W + 1);
  localparam int REM_W      = $clog2(NDIG + 1);

  typedef enum logic [1:0] {
    REQ_FIRST  = 2'd0,
    REQ_SECOND = 2'd1,
    REQ_FINISH = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // Control from the top level to the accumulator bank.
  typedef struct packed {
    logic       ld_first;
    logic       ld_second;
    logic       clear;
    logic [3:0] digit;
  } acc_ctl_t;

endpackage

### hdl/decimal_digit_array_adder_top.sv
// ----------------------------------------------------------------------------
// decimal_digit_array_adder_top
// Accumulates two decimal operands digit by digit and streams out the digits
// of their sum, most significant first.
// ----------------------------------------------------------------------------
//  channel | ports                  | contents
//  --------+------------------------+---------------------------------------
//  in      | in_tvalid/tready/tdata | tdata[3:0] digit, tuser[1:0] req_type
//  out     | out_tvalid/tready/...  | tdata[3:0] sum_digit, tlast last,
//          |                        | tuser[0] overflow
//
// A finish runs a shift-and-correct conversion over all SUM_W (55) bits of the sum,
// then a leading zero skip, then outputs one digit per cycle while out_tready is high.
// in_tready stays low from a finish until its last digit is taken.
// out_tready low holds the current digit; reset is synchronous, active low.
// ----------------------------------------------------------------------------
module decimal_digit_array_adder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [3:0] digit, [7:4] zero
  input  logic [1:0] in_tuser,   // [1:0] req_type
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [3:0] sum_digit, [7:4] zero
  output logic       out_tlast,
  output logic [0:0] out_tuser   // [0] overflow
);
  import ddaa_pkg::*;

  acc_ctl_t         acc_ctl;
  logic [SUM_W-1:0] sum;
  logic             too_long;
  logic             conv_idle;
  logic             in_xfer;
  logic             start;
  logic [3:0]       sum_digit;
  logic             ovf_flag;

  assign in_tready = conv_idle;
  assign in_xfer   = in_tvalid && in_tready;
  assign start     = in_xfer && (in_tuser == REQ_FINISH);

  always_comb begin
    acc_ctl.ld_first  = in_xfer && (in_tuser == REQ_FIRST);
    acc_ctl.ld_second = in_xfer && (in_tuser == REQ_SECOND);
    acc_ctl.clear     = start;
    acc_ctl.digit     = in_tdata[3:0];
  end

  ddaa_acc u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (acc_ctl),
    .sum      (sum),
    .too_long (too_long)
  );

  ddaa_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sum       (sum),
    .ovf       (too_long),
    .idle      (conv_idle),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_digit (sum_digit),
    .out_last  (out_tlast),
    .out_ovf   (ovf_flag)
  );

  assign out_tdata = {4'd0, sum_digit};
  assign out_tuser = ovf_flag;

endmodule

### hdl/ddaa_acc.sv
// ----------------------------------------------------------------------------
// ddaa_acc
// Operand accumulators: value = value*10 + digit, digit count limit, error flag.
// ----------------------------------------------------------------------------
module ddaa_acc (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ddaa_pkg::acc_ctl_t     ctl,
  output logic [ddaa_pkg::SUM_W-1:0] sum,
  output logic                   too_long
);
  import ddaa_pkg::*;

  logic [VAL_W-1:0] first_r, first_nxt, second_r, second_nxt;
  logic [CNT_W-1:0] first_cnt_r, first_cnt_nxt, second_cnt_r, second_cnt_nxt;
  logic             too_long_r, too_long_nxt;
  logic [3:0]       dsat;
  logic [VAL_W-1:0] base, scaled;
  logic             base_full;

  assign dsat      = (ctl.digit > 4'd9) ? 4'd9 : ctl.digit;
  assign base      = ctl.ld_first ? first_r : second_r;
  assign base_full = ctl.ld_first ? (first_cnt_r >= CNT_W'(MAX_DIGITS))
                                  : (second_cnt_r >= CNT_W'(MAX_DIGITS));
  // times ten as two shifts and one add
  assign scaled    = (base << 3) + (base << 1) + VAL_W'(dsat);

  assign sum      = SUM_W'(first_r) + SUM_W'(second_r);
  assign too_long = too_long_r;

  always_comb begin
    first_nxt      = first_r;
    second_nxt     = second_r;
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    too_long_nxt   = too_long_r;
    if (ctl.clear) begin
      first_nxt      = '0;
      second_nxt     = '0;
      first_cnt_nxt  = '0;
      second_cnt_nxt = '0;
      too_long_nxt   = 1'b0;
    end else if (ctl.ld_first || ctl.ld_second) begin
      if (base_full) begin
        // drop the digit, flag the sum
        too_long_nxt = 1'b1;
      end else if (ctl.ld_first) begin
        first_nxt     = scaled;
        first_cnt_nxt = first_cnt_r + 1'b1;
      end else begin
        second_nxt     = scaled;
        second_cnt_nxt = second_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r      <= '0;
      second_r     <= '0;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      too_long_r   <= 1'b0;
    end else begin
      first_r      <= first_nxt;
      second_r     <= second_nxt;
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      too_long_r   <= too_long_nxt;
    end
  end

endmodule

### hdl/ddaa_conv.sv
// ----------------------------------------------------------------------------
// ddaa_conv
// Binary to decimal converter: one shift-and-correct step per cycle, then
// leading zero skip and digit output, most significant first.
// ----------------------------------------------------------------------------
module ddaa_conv (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ddaa_pkg::SUM_W-1:0] sum,
  input  logic                       ovf,
  output logic                       idle,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [3:0]                 out_digit,
  output logic                       out_last,
  output logic                       out_ovf
);
  import ddaa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SKIP = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [SUM_W-1:0]     bin_r, bin_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [BCD_W-1:0]     bcd_step;
  logic [BCD_W-1:0]     bcd_adj;
  logic [3:0]           top_digit;

  // conversion step: add three to every digit at five or above, then shift in a bit
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                     : bcd_r[4*i +: 4];
    end
    bcd_step = {bcd_adj[BCD_W-2:0], bin_r[SUM_W-1]};
  end

  assign top_digit = bcd_r[BCD_W-1 -: 4];

  always_comb begin
    state_nxt   = state_r;
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    bit_cnt_nxt = bit_cnt_r;
    rem_nxt     = rem_r;
    ovf_nxt     = ovf_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          bin_nxt     = sum;
          bcd_nxt     = '0;
          bit_cnt_nxt = BIT_CNT_W'(SUM_W);
          ovf_nxt     = ovf;
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt     = bcd_step;
        bin_nxt     = bin_r << 1;
        bit_cnt_nxt = bit_cnt_r - 1'b1;
        if (bit_cnt_r == BIT_CNT_W'(1)) begin
          rem_nxt   = REM_W'(NDIG);
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (top_digit == 4'd0 && rem_r != REM_W'(1)) begin
          bcd_nxt = bcd_r << 4;
          rem_nxt = rem_r - 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          bcd_nxt = bcd_r << 4;
          rem_nxt = rem_r - 1'b1;
          if (rem_r == REM_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    rem_r     <= rem_nxt;
    ovf_r     <= ovf_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign out_digit = top_digit;
  assign out_last  = (rem_r == REM_W'(1));
  assign out_ovf   = ovf_r;

endmodule

### hdl/ddaa_checker.sv
// ----------------------------------------------------------------------------
// ddaa_checker
// Port-level checks for the decimal digit array adder, bound to the top level.
// ----------------------------------------------------------------------------
module ddaa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [1:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [0:0] out_tuser
);
  import ddaa_pkg::*;

  // stalled output transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("output payload changed while stalled");

  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input accepted while sum digits pending");

  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_FINISH |=> !in_tready)
    else $error("input ready right after finish");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("digit after last");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= 4'd9 && out_tdata[7:4] == 4'd0)
    else $error("sum digit out of range");

endmodule

bind decimal_digit_array_adder_top ddaa_checker u_ddaa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
